>>> rtl/psbp_pkg.sv
// ----------------------------------------------------------------------------
// psbp_pkg
// Types, widths and codes shared by the packet sequence block placer.
// ----------------------------------------------------------------------------
`default_nettype none

package psbp_pkg;

  localparam int FLEN_W     = 16;
  localparam int HDR_W      = 40;
  localparam int ANT_W      = 16;
  localparam int SEQ_W      = 35;
  localparam int CG_W       = 10;
  localparam int SNAP_W     = 10;
  localparam int PPB_W      = 21;
  localparam int KIND_W     = 3;
  localparam int OFF_W      = 20;
  localparam int SLOT_W     = 5;
  localparam int TOT_W      = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 35;

  // seq * channel_groups * snapshots
  localparam int PROD_W = SEQ_W + CG_W + SNAP_W;
  // ant * channel_groups
  localparam int AG_W   = ANT_W + CG_W;

  // x / 3 for a 26-bit x: (x * ceil(2^27 / 3)) >> 27
  localparam int            DIV3_SHIFT = AG_W + 1;
  localparam logic [AG_W-1:0] DIV3_RECIP = 26'd44739243;

  localparam int TEMP_DEPTH_DEF = 32;
  localparam int INDEX_BITS_DEF = 48;
  localparam int MAX_BLOCK_DEF  = 1048576;

  localparam logic [SEQ_W-1:0] NEVER_START = 35'd10000;
  localparam logic [SEQ_W-1:0] START_LEAD  = 35'd50;

  localparam logic [SEQ_W-1:0]  START_RESET = NEVER_START;
  localparam logic [PPB_W-1:0]  PPB_RESET   = 21'd1048576;

  typedef enum logic [KIND_W-1:0] {
    K_BAD_LEN       = 3'd0,
    K_NOT_ARMED     = 3'd1,
    K_PLACED        = 3'd2,
    K_DEFERRED      = 3'd3,
    K_DISCARDED     = 3'd4,
    K_BLOCK_DONE    = 3'd5,
    K_DRAIN_PLACED  = 3'd6,
    K_DRAIN_DISCARD = 3'd7
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_SEQUENCE    = 3'd0,
    CFG_FRAME_LENGTH      = 3'd1,
    CFG_CHANNEL_GROUPS    = 3'd2,
    CFG_SNAPSHOTS         = 3'd3,
    CFG_PACKETS_PER_BLOCK = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [FLEN_W-1:0] frame_length;
    logic [HDR_W-1:0]  header_bytes;
    logic [ANT_W-1:0]  antenna_word;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] result_kind;
    logic              buffer_half;
    logic [OFF_W-1:0]  packet_offset;
    logic [SLOT_W-1:0] temp_slot;
    logic [PPB_W-1:0]  dropped_in_block;
    logic [TOT_W-1:0]  received_total;
    logic [TOT_W-1:0]  dropped_total;
    logic              last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [SEQ_W-1:0]  start_sequence;
    logic [FLEN_W-1:0] expected_frame_length;
    logic [CG_W-1:0]   channel_groups;
    logic [SNAP_W-1:0] snapshots;
    logic [PPB_W-1:0]  packets_per_block;
  } cfg_t;

  typedef enum logic [1:0] {F_IDLE, F_MUL1, F_MUL2, F_PUSH} front_state_t;

  typedef enum logic [2:0] {
    B_IDLE, B_EVAL, B_PLACE, B_DONE, B_READ, B_DRAIN
  } back_state_t;

endpackage

`default_nettype wire

>>> rtl/psbp_front.sv
// ----------------------------------------------------------------------------
// psbp_front
// Accepts headers, checks length and computes sequence, packet index and
// start window through a short multiply sequence.
// ----------------------------------------------------------------------------
`default_nettype none

module psbp_front #(
  parameter int INDEX_BITS = psbp_pkg::INDEX_BITS_DEF,
  localparam int REC_W = 1 + psbp_pkg::SEQ_W + 2 * INDEX_BITS
) (
  input  wire                     clk,
  input  wire                     rst,
  input  psbp_pkg::cfg_t          cfg,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  psbp_pkg::in_item_t      in_data,
  input  wire                     full,
  output logic                    push,
  output logic [REC_W-1:0]        rec
);
  import psbp_pkg::*;

  localparam int SUM_W = (INDEX_BITS > PROD_W) ? INDEX_BITS : PROD_W;

  front_state_t            state, state_next;
  logic                    bad;
  logic [SEQ_W-1:0]        seq;
  logic [ANT_W-1:0]        ant;
  logic [SEQ_W+CG_W-1:0]   p1, q1;
  logic [AG_W-1:0]         a1;
  logic [PROD_W-1:0]       p2, q2;
  logic [2*AG_W-1:0]       a2;
  logic [SUM_W-1:0]        idx_sum, ws_sum;

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE:  if (in_valid) state_next = F_MUL1;
      F_MUL1:  state_next = F_MUL2;
      F_MUL2:  state_next = F_PUSH;
      F_PUSH:  if (!full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        if (in_valid) begin
          bad <= (in_data.frame_length != cfg.expected_frame_length);
          seq <= in_data.header_bytes[HDR_W-1:HDR_W-SEQ_W];
          ant <= in_data.antenna_word;
        end
      end
      F_MUL1: begin
        p1 <= seq * cfg.channel_groups;
        q1 <= cfg.start_sequence * cfg.channel_groups;
        a1 <= ant * cfg.channel_groups;
      end
      F_MUL2: begin
        p2 <= p1 * cfg.snapshots;
        q2 <= q1 * cfg.snapshots;
        a2 <= a1 * DIV3_RECIP;
      end
      default: ;
    endcase
  end

  assign idx_sum  = SUM_W'(p2 >> 1) + SUM_W'(a2 >> DIV3_SHIFT);
  assign ws_sum   = SUM_W'(q2 >> 1);
  assign in_ready = (state == F_IDLE);
  assign push     = (state == F_PUSH) && !full;
  assign rec      = {bad, seq, idx_sum[INDEX_BITS-1:0], ws_sum[INDEX_BITS-1:0]};

endmodule

`default_nettype wire

>>> rtl/psbp_queue.sv
// ----------------------------------------------------------------------------
// psbp_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module psbp_queue #(
  parameter int W = 8
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          push,
  input  wire [W-1:0]  wr_data,
  input  wire          pop,
  output logic [W-1:0] rd_data,
  output logic         empty,
  output logic         full
);
  logic [W-1:0] slot [2];
  logic         wr_ptr, rd_ptr;
  logic [1:0]   count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= wr_data;
  end

  assign rd_data = slot[rd_ptr];
  assign empty   = (count == 2'd0);
  assign full    = (count == 2'd2);

endmodule

`default_nettype wire

>>> rtl/psbp_back.sv
// ----------------------------------------------------------------------------
// psbp_back
// Arms, places, defers or discards each packet, closes blocks and drains
// the temp store into the new block.
// ----------------------------------------------------------------------------
`default_nettype none

module psbp_back #(
  parameter int INDEX_BITS        = psbp_pkg::INDEX_BITS_DEF,
  parameter int TEMP_DEPTH        = psbp_pkg::TEMP_DEPTH_DEF,
  parameter int MAX_BLOCK_PACKETS = psbp_pkg::MAX_BLOCK_DEF,
  localparam int REC_W = 1 + psbp_pkg::SEQ_W + 2 * INDEX_BITS
) (
  input  wire                 clk,
  input  wire                 rst,
  input  psbp_pkg::cfg_t      cfg,
  input  wire [REC_W-1:0]     rec,
  input  wire                 empty,
  output logic                pop,
  output logic                out_valid,
  input  wire                 out_ready,
  output psbp_pkg::out_item_t out_data
);
  import psbp_pkg::*;

  localparam int CW = $clog2(TEMP_DEPTH + 1);
  localparam int AW = (TEMP_DEPTH > 1) ? $clog2(TEMP_DEPTH) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(TEMP_DEPTH);

  back_state_t           state, state_next;
  logic                  r_bad;
  logic [SEQ_W-1:0]      r_seq;
  logic [INDEX_BITS-1:0] r_idx, r_ws0;
  logic                  armed, armed_next;
  logic                  started, started_next;
  logic [INDEX_BITS-1:0] window_start, window_start_next;
  logic [PPB_W-1:0]      block_fill, block_fill_next;
  logic                  active_half, active_half_next;
  logic [CW-1:0]         deferred_count, deferred_count_next;
  logic [CW-1:0]         drain_i, drain_i_next;
  logic [TOT_W-1:0]      received_count, received_count_next;
  logic [TOT_W-1:0]      dropped_count, dropped_count_next;
  logic [INDEX_BITS-1:0] mem [TEMP_DEPTH];
  logic [INDEX_BITS-1:0] rd_data;
  logic                  wr_en;
  logic [PPB_W-1:0]      n, drop;
  logic [SEQ_W-1:0]      thr;
  logic                  slot_free, emit;
  out_item_t             emit_data;

  function automatic logic in_block(input logic [INDEX_BITS-1:0] idx,
                                    input logic [INDEX_BITS-1:0] ws,
                                    input logic [PPB_W-1:0] size);
    logic [INDEX_BITS-1:0] diff;
    diff = idx - ws;
    return (idx >= ws) && (diff < INDEX_BITS'(size));
  endfunction

  // clamp block size to 1..MAX_BLOCK_PACKETS
  always_comb begin
    if (cfg.packets_per_block == '0) begin
      n = PPB_W'(1);
    end else if (32'(cfg.packets_per_block) > 32'(MAX_BLOCK_PACKETS)) begin
      n = PPB_W'(MAX_BLOCK_PACKETS);
    end else begin
      n = cfg.packets_per_block;
    end
  end

  assign thr       = (cfg.start_sequence > START_LEAD) ? cfg.start_sequence - START_LEAD : '0;
  assign drop      = (block_fill < n) ? n - block_fill : '0;
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next           = state;
    armed_next           = armed;
    started_next         = started;
    window_start_next    = window_start;
    block_fill_next      = block_fill;
    active_half_next     = active_half;
    deferred_count_next  = deferred_count;
    drain_i_next         = drain_i;
    received_count_next  = received_count;
    dropped_count_next   = dropped_count;
    pop                  = 1'b0;
    wr_en                = 1'b0;
    emit                 = 1'b0;
    emit_data            = '0;
    emit_data.received_total = received_count;
    emit_data.dropped_total  = dropped_count;
    case (state)
      B_IDLE: begin
        if (!empty) begin
          pop        = 1'b1;
          state_next = B_EVAL;
        end
      end
      B_EVAL: begin
        if (slot_free) begin
          if (r_bad) begin
            emit                  = 1'b1;
            emit_data.result_kind = K_BAD_LEN;
            emit_data.last_of_run = 1'b1;
            state_next            = B_IDLE;
          end else if (!armed && !(r_seq >= thr && cfg.start_sequence != NEVER_START)) begin
            emit                  = 1'b1;
            emit_data.result_kind = K_NOT_ARMED;
            emit_data.last_of_run = 1'b1;
            state_next            = B_IDLE;
          end else begin
            armed_next = 1'b1;
            if (!started) begin
              started_next      = 1'b1;
              window_start_next = r_ws0;
            end
            state_next = B_PLACE;
          end
        end
      end
      B_PLACE: begin
        if (slot_free) begin
          emit = 1'b1;
          if (in_block(r_idx, window_start, n)) begin
            block_fill_next         = block_fill + PPB_W'(1);
            emit_data.result_kind   = K_PLACED;
            emit_data.buffer_half   = active_half;
            emit_data.packet_offset = OFF_W'(r_idx - window_start);
          end else if (r_idx > window_start && deferred_count < DEPTH_C) begin
            wr_en                   = 1'b1;
            deferred_count_next     = deferred_count + CW'(1);
            emit_data.result_kind   = K_DEFERRED;
            emit_data.temp_slot     = SLOT_W'(deferred_count);
          end else begin
            emit_data.result_kind   = K_DISCARDED;
          end
          if (block_fill_next >= n || deferred_count_next >= DEPTH_C) begin
            state_next = B_DONE;
          end else begin
            emit_data.last_of_run = 1'b1;
            state_next            = B_IDLE;
          end
        end
      end
      B_DONE: begin
        if (slot_free) begin
          received_count_next        = received_count + TOT_W'(block_fill);
          dropped_count_next         = dropped_count + TOT_W'(drop);
          emit                       = 1'b1;
          emit_data.result_kind      = K_BLOCK_DONE;
          emit_data.buffer_half      = active_half;
          emit_data.dropped_in_block = drop;
          emit_data.received_total   = received_count_next;
          emit_data.dropped_total    = dropped_count_next;
          emit_data.last_of_run      = (deferred_count == '0);
          window_start_next          = window_start + INDEX_BITS'(n);
          block_fill_next            = '0;
          active_half_next           = ~active_half;
          drain_i_next               = '0;
          state_next = (deferred_count == '0) ? B_IDLE : B_READ;
        end
      end
      B_READ: state_next = B_DRAIN;
      B_DRAIN: begin
        if (slot_free) begin
          emit                = 1'b1;
          emit_data.temp_slot = SLOT_W'(drain_i);
          if (in_block(rd_data, window_start, n)) begin
            block_fill_next         = block_fill + PPB_W'(1);
            emit_data.result_kind   = K_DRAIN_PLACED;
            emit_data.buffer_half   = active_half;
            emit_data.packet_offset = OFF_W'(rd_data - window_start);
          end else begin
            emit_data.result_kind   = K_DRAIN_DISCARD;
          end
          if (drain_i + CW'(1) == deferred_count) begin
            emit_data.last_of_run = 1'b1;
            deferred_count_next   = '0;
            state_next            = B_IDLE;
          end else begin
            drain_i_next = drain_i + CW'(1);
            state_next   = B_READ;
          end
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= B_IDLE;
      armed          <= 1'b0;
      started        <= 1'b0;
      window_start   <= '0;
      block_fill     <= '0;
      active_half    <= 1'b0;
      deferred_count <= '0;
      drain_i        <= '0;
      received_count <= '0;
      dropped_count  <= '0;
      out_valid      <= 1'b0;
    end else begin
      state          <= state_next;
      armed          <= armed_next;
      started        <= started_next;
      window_start   <= window_start_next;
      block_fill     <= block_fill_next;
      active_half    <= active_half_next;
      deferred_count <= deferred_count_next;
      drain_i        <= drain_i_next;
      received_count <= received_count_next;
      dropped_count  <= dropped_count_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      {r_bad, r_seq, r_idx, r_ws0} <= rec;
    end
    if (emit) begin
      out_data <= emit_data;
    end
  end

  // temp store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) mem[deferred_count[AW-1:0]] <= r_idx;
    rd_data <= mem[drain_i[AW-1:0]];
  end

endmodule

`default_nettype wire

>>> rtl/packet_sequence_block_placer.sv
// ----------------------------------------------------------------------------
// packet_sequence_block_placer
// Places captured packet headers into the blocks of a double buffer.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_data) takes one header per item. The
// front holds an item through capture, two multiply steps and hand-off and
// accepts no new item until that hand-off is done; its multiply sequence
// sets that pace. A two-entry queue feeds the back, which pops and evaluates
// each item before its first result. A block completion adds one result, and
// the drain of the temp store emits one result per stored entry. Results leave
// through one output register (out_valid/out_ready/out_data); last_of_run
// marks the final result of an item. When the receiver stalls the back holds
// its result and the front keeps working until the queue is full.
// Configuration writes (cfg_valid/cfg_ready/cfg_index/cfg_data) are always
// taken; indexes past the register list are ignored. Reset restores the
// register defaults, disarms the block, clears the counters and empties the
// store.
// ----------------------------------------------------------------------------
`default_nettype none

module packet_sequence_block_placer #(
  parameter int TEMP_DEPTH        = psbp_pkg::TEMP_DEPTH_DEF,
  parameter int INDEX_BITS        = psbp_pkg::INDEX_BITS_DEF,
  parameter int MAX_BLOCK_PACKETS = psbp_pkg::MAX_BLOCK_DEF
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  psbp_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  wire                                out_ready,
  output psbp_pkg::out_item_t                out_data,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire [psbp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [psbp_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import psbp_pkg::*;

  localparam int REC_W = 1 + SEQ_W + 2 * INDEX_BITS;

  cfg_t             cfg;
  logic [REC_W-1:0] f_rec, q_rec;
  logic             f_push, q_pop, q_empty, q_full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_sequence        <= START_RESET;
      cfg.expected_frame_length <= '0;
      cfg.channel_groups        <= CG_W'(1);
      cfg.snapshots             <= SNAP_W'(1);
      cfg.packets_per_block     <= PPB_RESET;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        CFG_START_SEQUENCE:    cfg.start_sequence        <= cfg_data[SEQ_W-1:0];
        CFG_FRAME_LENGTH:      cfg.expected_frame_length <= cfg_data[FLEN_W-1:0];
        CFG_CHANNEL_GROUPS:    cfg.channel_groups        <= cfg_data[CG_W-1:0];
        CFG_SNAPSHOTS:         cfg.snapshots             <= cfg_data[SNAP_W-1:0];
        CFG_PACKETS_PER_BLOCK: cfg.packets_per_block     <= cfg_data[PPB_W-1:0];
        default: ;
      endcase
    end
  end

  psbp_front #(.INDEX_BITS(INDEX_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .full     (q_full),
    .push     (f_push),
    .rec      (f_rec)
  );

  psbp_queue #(.W(REC_W)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (f_push),
    .wr_data (f_rec),
    .pop     (q_pop),
    .rd_data (q_rec),
    .empty   (q_empty),
    .full    (q_full)
  );

  psbp_back #(
    .INDEX_BITS        (INDEX_BITS),
    .TEMP_DEPTH        (TEMP_DEPTH),
    .MAX_BLOCK_PACKETS (MAX_BLOCK_PACKETS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .rec       (q_rec),
    .empty     (q_empty),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

>>> rtl/psbp_checker.sv
// ----------------------------------------------------------------------------
// psbp_checker
// Port-level checks for the packet sequence block placer.
// ----------------------------------------------------------------------------
`default_nettype none

module psbp_checker (
  input wire                 clk,
  input wire                 rst,
  input wire                 out_valid,
  input wire                 out_ready,
  input psbp_pkg::out_item_t out_data
);
  import psbp_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.result_kind == K_BAD_LEN ||
                  out_data.result_kind == K_NOT_ARMED) |-> out_data.last_of_run)
    else $error("rejected item did not end its run");

  a_done_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.result_kind == K_BLOCK_DONE |->
      out_data.packet_offset == '0 && out_data.temp_slot == '0)
    else $error("block completion carries slot fields");

  a_totals_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_data.result_kind != K_BLOCK_DONE |=>
      !out_valid || out_data.result_kind == K_BLOCK_DONE ||
      (out_data.received_total == $past(out_data.received_total) &&
       out_data.dropped_total == $past(out_data.dropped_total)))
    else $error("totals changed outside a block completion");

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind packet_sequence_block_placer psbp_checker u_psbp_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
